>>> hw/rtl/tti_pkg.sv
// ----------------------------------------------------------------------------
// tti_pkg: shared types and constants of the trajectory table interpolator
// Holds the table geometry, the sequencer states and the register map.
// ----------------------------------------------------------------------------
package tti_pkg;

   localparam int TABLE_DEPTH = 1024;
   localparam int IDX_W = $clog2(TABLE_DEPTH);
   localparam int CNT_W = 11;
   localparam int BACKUP_STEPS = 10;
   localparam int NUM_CHAN = 9;
   localparam int CHAN_W = 4;
   localparam int ROW_W = 32 * NUM_CHAN;

   localparam logic [0:0] REQ_LOAD = 1'b0;
   localparam logic [0:0] REQ_QUERY = 1'b1;
   localparam logic [0:0] CSR_ENTRY_COUNT = 1'b0;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_RANGE_RD,
      ST_RANGE_CHK,
      ST_SCAN_RD,
      ST_SCAN_CHK,
      ST_SEG_RD,
      ST_SEG_WAIT,
      ST_SETUP,
      ST_MUL,
      ST_DIV,
      ST_ACC,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic start;
      logic busy;
      logic done;
   } div_ctrl_type;

endpackage

>>> hw/rtl/trajectory_table_interpolator_top.sv
// ----------------------------------------------------------------------------
// trajectory_table_interpolator_top: motion table with linear interpolation
// Loads table rows and answers time queries with nine interpolated channels.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake         Content
// req_      in         valid / stall     load row or query time
// rsp_      out        valid / stall     nine channels, segment, range flag
// csr_      in         APB-style         entry_count
// A load item is written straight into the table and leaves the request port free. A query item
// reads the first and last rows, scans rows one at a time, reads the two segment rows, sets up and
// runs the divider once per channel; for equal row times it skips the divider and offers its result.
// Reset is synchronous; table memories hold no reset value.
// Request stall stays high from a query's acceptance until its result item is taken.
module trajectory_table_interpolator_top (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [0:0]                req_type,
   input  logic [9:0]                req_row_index,
   input  logic [31:0]               req_time_value,
   input  logic signed [31:0]        req_pos_x,
   input  logic signed [31:0]        req_pos_y,
   input  logic signed [31:0]        req_pos_z,
   input  logic signed [31:0]        req_vel_x,
   input  logic signed [31:0]        req_vel_y,
   input  logic signed [31:0]        req_vel_z,
   input  logic signed [31:0]        req_acc_x,
   input  logic signed [31:0]        req_acc_y,
   input  logic signed [31:0]        req_acc_z,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic signed [31:0]        rsp_out_pos_x,
   output logic signed [31:0]        rsp_out_pos_y,
   output logic signed [31:0]        rsp_out_pos_z,
   output logic signed [31:0]        rsp_out_vel_x,
   output logic signed [31:0]        rsp_out_vel_y,
   output logic signed [31:0]        rsp_out_vel_z,
   output logic signed [31:0]        rsp_out_acc_x,
   output logic signed [31:0]        rsp_out_acc_y,
   output logic signed [31:0]        rsp_out_acc_z,
   output logic [9:0]                rsp_segment_used,
   output logic                      rsp_out_of_range,
   input  logic                      psel,
   input  logic                      penable,
   input  logic                      pwrite,
   input  logic [1:0]                paddr,
   input  logic [31:0]               pwdata,
   output logic [31:0]               prdata,
   output logic                      pready
);
   import tti_pkg::*;

   state_type state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [IDX_W-1:0] ptr_ff, ptr_in, j_ff, j_in, seg_ff, seg_in;
   logic [31:0]      t_ff, t_in, t0_ff, t0_in, t1_ff, t1_in;
   logic [ROW_W-1:0] rowa_ff, rowa_in, rowb_ff, rowb_in, res_ff, res_in;
   logic [CHAN_W-1:0] ch_ff, ch_in;
   logic             oor_ff, oor_in, neg_ff, neg_in, first_ff, first_in;
   logic [63:0]      prod;
   logic [IDX_W-1:0] rd_addr;
   logic [31:0]      rd_time;
   logic [ROW_W-1:0] rd_row;
   logic             req_acc, ld_en;
   div_ctrl_type     div_st;
   logic             div_start;
   logic [63:0]      quot;
   logic [IDX_W:0]   n_val, last_idx, start_s, ptr_back;
   logic [31:0]      mdt, mden;
   logic             neg_dt, neg_den;
   logic signed [32:0] a_v, b_v, diff;
   logic [31:0]      mdiff;
   logic signed [35:0] sum;
   logic [31:0]      sat_v;

   assign pready = 1'b1;
   assign prdata = {21'd0, count_ff};
   assign req_acc = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign ld_en = req_acc && (req_type == REQ_LOAD);
   assign rsp_valid = (state_ff == ST_OUT);

   always_comb begin
      n_val = (count_ff < CNT_W'(2)) ? (IDX_W+1)'(2) :
              (count_ff > CNT_W'(TABLE_DEPTH)) ? (IDX_W+1)'(TABLE_DEPTH) :
              (IDX_W+1)'(count_ff);
      last_idx = n_val - (IDX_W+1)'(2);
      ptr_back = ({1'b0, ptr_ff} >= (IDX_W+1)'(BACKUP_STEPS)) ?
                 {1'b0, ptr_ff} - (IDX_W+1)'(BACKUP_STEPS) : '0;
      start_s = (ptr_back > last_idx) ? last_idx : ptr_back;
      neg_dt = t_ff < t0_ff;
      mdt = neg_dt ? t0_ff - t_ff : t_ff - t0_ff;
      neg_den = t1_ff < t0_ff;
      mden = neg_den ? t0_ff - t1_ff : t1_ff - t0_ff;
      a_v = 33'(signed'(rowa_ff[32*ch_ff +: 32]));
      b_v = 33'(signed'(rowb_ff[32*ch_ff +: 32]));
      diff = b_v - a_v;
      mdiff = diff[32] ? 32'(-diff) : diff[31:0];
      prod = 64'(mdt) * 64'(mdiff);
      sum = neg_ff ? 36'(a_v) - 36'(quot[34:0]) : 36'(a_v) + 36'(quot[34:0]);
      if (quot > 64'h4_0000_0000) begin
         sat_v = neg_ff ? 32'h8000_0000 : 32'h7FFF_FFFF;
      end else if (sum > 36'sh7FFF_FFFF) begin
         sat_v = 32'h7FFF_FFFF;
      end else if (sum < -36'sh8000_0000) begin
         sat_v = 32'h8000_0000;
      end else begin
         sat_v = sum[31:0];
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_acc && req_type == REQ_QUERY) begin
               state_in = ST_RANGE_RD;
            end
         end
         ST_RANGE_RD: state_in = ST_RANGE_CHK;
         ST_RANGE_CHK: state_in = ST_SCAN_RD;
         ST_SCAN_RD: state_in = ST_SCAN_CHK;
         ST_SCAN_CHK: begin
            if ({1'b0, j_ff} >= n_val - 1'b1 || rd_time >= t_ff) begin
               state_in = ST_SEG_RD;
            end else begin
               state_in = ST_SCAN_RD;
            end
         end
         ST_SEG_RD: state_in = ST_SEG_WAIT;
         ST_SEG_WAIT: state_in = first_ff ? ST_SEG_RD : ST_SETUP;
         ST_SETUP: state_in = (mden == 32'd0) ? ST_OUT : ST_MUL;
         ST_MUL: state_in = ST_DIV;
         ST_DIV: state_in = div_st.done ? ST_ACC : ST_DIV;
         ST_ACC: state_in = (ch_ff == CHAN_W'(NUM_CHAN-1)) ? ST_OUT : ST_MUL;
         ST_OUT: state_in = rsp_stall ? ST_OUT : ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      count_in = count_ff;
      ptr_in = ptr_ff; j_in = j_ff; seg_in = seg_ff; t_in = t_ff;
      t0_in = t0_ff; t1_in = t1_ff; rowa_in = rowa_ff; rowb_in = rowb_ff;
      res_in = res_ff; ch_in = ch_ff; oor_in = oor_ff; neg_in = neg_ff;
      first_in = first_ff; div_start = 1'b0;
      rd_addr = j_ff;
      if (psel && penable && pwrite && paddr[1:1] == CSR_ENTRY_COUNT
          && paddr[0] == 1'b0) begin
         count_in = pwdata[CNT_W-1:0];
      end
      unique case (state_ff)
         ST_IDLE: begin
            t_in = req_time_value;
            j_in = start_s[IDX_W-1:0] + 1'b1;
            rd_addr = '0;
            oor_in = 1'b0;
         end
         ST_RANGE_RD: begin
            rd_addr = last_idx[IDX_W-1:0] + 1'b1;
            oor_in = (t_ff < rd_time);
         end
         ST_RANGE_CHK: begin
            oor_in = oor_ff | (t_ff > rd_time);
         end
         ST_SCAN_RD: rd_addr = j_ff;
         ST_SCAN_CHK: begin
            if ({1'b0, j_ff} >= n_val - 1'b1 || rd_time >= t_ff) begin
               if (rd_time > t_ff) begin
                  seg_in = j_ff - 1'b1;
               end else begin
                  seg_in = ({1'b0, j_ff} > last_idx) ? last_idx[IDX_W-1:0] : j_ff;
               end
               if ({1'b0, j_ff} == n_val - 1'b1 && rd_time < t_ff) begin
                  seg_in = last_idx[IDX_W-1:0];
               end
               first_in = 1'b1;
            end else begin
               j_in = j_ff + 1'b1;
            end
         end
         ST_SEG_RD: rd_addr = first_ff ? seg_ff : seg_ff + 1'b1;
         ST_SEG_WAIT: begin
            if (first_ff) begin
               t0_in = rd_time; rowa_in = rd_row; first_in = 1'b0;
               rd_addr = seg_ff + 1'b1;
            end else begin
               t1_in = rd_time; rowb_in = rd_row;
            end
            ptr_in = seg_ff;
         end
         ST_SETUP: begin
            ch_in = '0;
            res_in = rowa_ff;
            rd_addr = '0;
         end
         ST_MUL: begin
            neg_in = neg_dt ^ neg_den ^ diff[32];
            div_start = 1'b1;
         end
         ST_DIV: begin
            if (ch_ff == '0) begin
               rd_addr = '0;
            end
         end
         ST_ACC: begin
            res_in[32*ch_ff +: 32] = sat_v;
            ch_in = ch_ff + 1'b1;
         end
         ST_OUT: ;
         default: ;
      endcase
   end

   tti_row_store u_store (
      .clock(clock), .wr_en(ld_en), .wr_addr(req_row_index),
      .wr_time(req_time_value),
      .wr_row({req_acc_z, req_acc_y, req_acc_x, req_vel_z, req_vel_y, req_vel_x,
               req_pos_z, req_pos_y, req_pos_x}),
      .rd_addr(rd_addr), .rd_time(rd_time), .rd_row(rd_row)
   );

   tti_divider u_div (
      .clock(clock), .reset(reset), .start(div_start),
      .dividend(prod), .divisor(mden), .status(div_st), .quotient(quot)
   );

   always_ff @(posedge clock) begin
      j_ff <= j_in; seg_ff <= seg_in; t_ff <= t_in;
      t0_ff <= t0_in; t1_ff <= t1_in; rowa_ff <= rowa_in; rowb_ff <= rowb_in;
      res_ff <= res_in; ch_ff <= ch_in; neg_ff <= neg_in;
      first_ff <= first_in; oor_ff <= oor_in;
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= CNT_W'(2);
         ptr_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         ptr_ff <= ptr_in;
      end
   end

   assign rsp_out_pos_x = res_ff[31:0];
   assign rsp_out_pos_y = res_ff[63:32];
   assign rsp_out_pos_z = res_ff[95:64];
   assign rsp_out_vel_x = res_ff[127:96];
   assign rsp_out_vel_y = res_ff[159:128];
   assign rsp_out_vel_z = res_ff[191:160];
   assign rsp_out_acc_x = res_ff[223:192];
   assign rsp_out_acc_y = res_ff[255:224];
   assign rsp_out_acc_z = res_ff[287:256];
   assign rsp_segment_used = seg_ff;
   assign rsp_out_of_range = oor_ff;

   a_stall_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall) else $error("request taken while result pending");
   a_div_in_div: assert property (@(posedge clock) disable iff (reset)
      div_st.busy |-> state_ff == ST_DIV) else $error("divider busy outside divide");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid) else $error("result dropped");
endmodule

>>> hw/rtl/tti_divider.sv
// ----------------------------------------------------------------------------
// tti_divider: restoring divider, one quotient bit per cycle
// Divides a 64-bit magnitude by a 32-bit magnitude.
// ----------------------------------------------------------------------------
module tti_divider (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [63:0]         dividend,
   input  logic [31:0]         divisor,
   output tti_pkg::div_ctrl_type status,
   output logic [63:0]         quotient
);
   import tti_pkg::*;

   logic [63:0] quot_ff, quot_in;
   logic [32:0] rem_ff, rem_in;
   logic [31:0] dsr_ff, dsr_in;
   logic [6:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in, done_ff, done_in;
   logic [32:0] trial;

   always_comb begin
      quot_in = quot_ff;
      rem_in = rem_ff;
      dsr_in = dsr_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial = {rem_ff[31:0], quot_ff[63]};
      if (start) begin
         quot_in = dividend;
         rem_in = '0;
         dsr_in = divisor;
         cnt_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, dsr_ff}) begin
            rem_in = trial - {1'b0, dsr_ff};
            quot_in = {quot_ff[62:0], 1'b1};
         end else begin
            rem_in = trial;
            quot_in = {quot_ff[62:0], 1'b0};
         end
         cnt_in = cnt_ff + 7'd1;
         if (cnt_ff == 7'd63) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      quot_ff <= quot_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign status = '{start: start, busy: busy_ff, done: done_ff};
   assign quotient = quot_ff;
endmodule

>>> hw/rtl/tti_row_store.sv
// ----------------------------------------------------------------------------
// tti_row_store: table memories for time stamps and row values
// One write port and one registered read port for each memory.
// ----------------------------------------------------------------------------
module tti_row_store (
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic [tti_pkg::IDX_W-1:0]  wr_addr,
   input  logic [31:0]                wr_time,
   input  logic [tti_pkg::ROW_W-1:0]  wr_row,
   input  logic [tti_pkg::IDX_W-1:0]  rd_addr,
   output logic [31:0]                rd_time,
   output logic [tti_pkg::ROW_W-1:0]  rd_row
);
   import tti_pkg::*;

   logic [31:0]    time_mem [TABLE_DEPTH];
   logic [ROW_W-1:0] row_mem [TABLE_DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         time_mem[wr_addr] <= wr_time;
         row_mem[wr_addr] <= wr_row;
      end
      rd_time <= time_mem[rd_addr];
      rd_row <= row_mem[rd_addr];
   end
endmodule

>>> tb/tb_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_checker: result predictor and scoreboard for the table interpolator
// Watches the request, result and register ports, mirrors the motion table,
// the segment pointer and the row count, works out each query's result and
// compares every result item field by field with the oldest one expected.
// ----------------------------------------------------------------------------
module tb_checker (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_stall,
   input  logic [0:0]         req_type,
   input  logic [9:0]         req_row_index,
   input  logic [31:0]        req_time_value,
   input  logic [31:0]        req_chan [tti_pkg::NUM_CHAN],
   input  logic               rsp_valid,
   input  logic               rsp_stall,
   input  logic [31:0]        rsp_chan [tti_pkg::NUM_CHAN],
   input  logic [9:0]         rsp_segment_used,
   input  logic               rsp_out_of_range,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [1:0]         paddr,
   input  logic [31:0]        pwdata,
   input  logic               pready,
   output int                 pending,
   output int                 failures
);
   import tti_pkg::*;

   localparam logic [1:0] ENTRY_COUNT_ADDR = 2'(4 * int'(CSR_ENTRY_COUNT));

   typedef struct {
      logic [31:0] chan [NUM_CHAN];
      logic [9:0]  segment;
      logic        out_of_range;
   } motion_sample_type;

   logic [31:0]    row_time [TABLE_DEPTH];
   logic [31:0]    row_chan [TABLE_DEPTH][NUM_CHAN];
   logic [9:0]     segment_ptr;
   logic [10:0]    row_count;
   motion_sample_type expected_motion [$];

   string chan_name [NUM_CHAN] = '{"out_pos_x", "out_pos_y", "out_pos_z",
                                   "out_vel_x", "out_vel_y", "out_vel_z",
                                   "out_acc_x", "out_acc_y", "out_acc_z"};

   function automatic logic [31:0] blend(longint lo_val, longint hi_val, bit neg_dt,
                                         bit [63:0] mag_dt, bit neg_den,
                                         bit [63:0] mag_den);
      longint    diff;
      longint    sum;
      bit        neg;
      bit [63:0] mag_diff;
      bit [63:0] step;
      if (mag_den == 0) begin
         return lo_val[31:0];
      end
      diff = hi_val - lo_val;
      neg = neg_dt ^ neg_den;
      if (diff < 0) begin
         mag_diff = -diff;
         neg = ~neg;
      end else begin
         mag_diff = diff;
      end
      step = (mag_dt * mag_diff) / mag_den;
      if (step > 64'h4_0000_0000) begin
         return neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
      end
      sum = neg ? lo_val - longint'(step) : lo_val + longint'(step);
      if (sum > 64'sd2147483647) begin
         sum = 64'sd2147483647;
      end
      if (sum < -64'sd2147483648) begin
         sum = -64'sd2147483648;
      end
      return sum[31:0];
   endfunction

   function automatic motion_sample_type interpolate(logic [31:0] t);
      int unsigned    n;
      int unsigned    s;
      int unsigned    j;
      int unsigned    seg;
      logic [31:0]    t0;
      logic [31:0]    t1;
      bit             neg_dt;
      bit             neg_den;
      bit [63:0]      mag_dt;
      bit [63:0]      mag_den;
      motion_sample_type m;
      n = row_count;
      if (n < 2) n = 2;
      if (n > TABLE_DEPTH) n = TABLE_DEPTH;
      s = (segment_ptr >= BACKUP_STEPS) ? segment_ptr - BACKUP_STEPS : 0;
      if (s > n - 2) s = n - 2;
      j = s + 1;
      while (j < n && row_time[j] < t) j++;
      if (j >= n) seg = n - 2;
      else if (row_time[j] > t) seg = j - 1;
      else seg = (j > n - 2) ? n - 2 : j;
      segment_ptr = seg[9:0];
      t0 = row_time[seg];
      t1 = row_time[seg + 1];
      neg_dt = t < t0;
      mag_dt = neg_dt ? 64'(t0 - t) : 64'(t - t0);
      neg_den = t1 < t0;
      mag_den = neg_den ? 64'(t0 - t1) : 64'(t1 - t0);
      for (int c = 0; c < NUM_CHAN; c++) begin
         m.chan[c] = blend(longint'(signed'(row_chan[seg][c])),
                           longint'(signed'(row_chan[seg + 1][c])),
                           neg_dt, mag_dt, neg_den, mag_den);
      end
      m.segment = seg[9:0];
      m.out_of_range = (t < row_time[0]) || (t > row_time[n - 1]);
      return m;
   endfunction

   always @(posedge clock) begin
      motion_sample_type m;
      if (reset) begin
         segment_ptr = '0;
         row_count = 11'd2;
         expected_motion.delete();
         failures = 0;
      end else begin
         if (psel && penable && pwrite && pready && paddr == ENTRY_COUNT_ADDR) begin
            row_count = pwdata[10:0];
         end
         if (req_valid && !req_stall) begin
            if (req_type == REQ_LOAD) begin
               row_time[req_row_index] = req_time_value;
               for (int c = 0; c < NUM_CHAN; c++) begin
                  row_chan[req_row_index][c] = req_chan[c];
               end
            end else begin
               expected_motion.push_back(interpolate(req_time_value));
            end
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_motion.size() == 0) begin
               $error("result item with no query outstanding");
               failures++;
            end else begin
               m = expected_motion.pop_front();
               for (int c = 0; c < NUM_CHAN; c++) begin
                  if (rsp_chan[c] !== m.chan[c]) begin
                     $error("%s expected %h actual %h", chan_name[c], m.chan[c], rsp_chan[c]);
                     failures++;
                  end
               end
               if (rsp_segment_used !== m.segment) begin
                  $error("segment_used expected %0d actual %0d", m.segment, rsp_segment_used);
                  failures++;
               end
               if (rsp_out_of_range !== m.out_of_range) begin
                  $error("out_of_range expected %b actual %b", m.out_of_range,
                         rsp_out_of_range);
                  failures++;
               end
            end
         end
      end
      pending <= expected_motion.size();
   end

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: stimulus and verdict for the trajectory table interpolator
// Loads motion tables, sweeps the row count over its range and issues time
// queries, both directed corner cases and random ones, with random gaps and
// back-pressure. The checker beside the block predicts and compares results.
// ----------------------------------------------------------------------------
module tb_top;
   import tti_pkg::*;

   localparam logic [1:0] ENTRY_COUNT_ADDR = 2'(4 * int'(CSR_ENTRY_COUNT));
   localparam int STALL_LIMIT = 20000;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   logic [0:0]        req_type = REQ_LOAD;
   logic [9:0]        req_row_index = '0;
   logic [31:0]       req_time_value = '0;
   logic [31:0]       req_chan [NUM_CHAN] = '{default: '0};
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   logic [31:0]       rsp_chan [NUM_CHAN];
   logic [9:0]        rsp_segment_used;
   logic              rsp_out_of_range;
   logic              psel = 1'b0;
   logic              penable = 1'b0;
   logic              pwrite = 1'b0;
   logic [1:0]        paddr = '0;
   logic [31:0]       pwdata = '0;
   logic [31:0]       prdata;
   logic              pready;
   int                pending;
   int                failures;
   bit                gaps_on = 1'b1;
   int                quiet_cycles = 0;
   logic [31:0]       time_shadow [TABLE_DEPTH];
   int                rows_filled = 0;
   int                active_rows = 2;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   trajectory_table_interpolator_top dut (
      .clock, .reset, .req_valid, .req_stall, .req_type, .req_row_index,
      .req_time_value,
      .req_pos_x(req_chan[0]), .req_pos_y(req_chan[1]), .req_pos_z(req_chan[2]),
      .req_vel_x(req_chan[3]), .req_vel_y(req_chan[4]), .req_vel_z(req_chan[5]),
      .req_acc_x(req_chan[6]), .req_acc_y(req_chan[7]), .req_acc_z(req_chan[8]),
      .rsp_valid, .rsp_stall,
      .rsp_out_pos_x(rsp_chan[0]), .rsp_out_pos_y(rsp_chan[1]),
      .rsp_out_pos_z(rsp_chan[2]), .rsp_out_vel_x(rsp_chan[3]),
      .rsp_out_vel_y(rsp_chan[4]), .rsp_out_vel_z(rsp_chan[5]),
      .rsp_out_acc_x(rsp_chan[6]), .rsp_out_acc_y(rsp_chan[7]),
      .rsp_out_acc_z(rsp_chan[8]),
      .rsp_segment_used, .rsp_out_of_range,
      .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
   );

   tb_checker checker_i (
      .clock, .reset, .req_valid, .req_stall, .req_type, .req_row_index,
      .req_time_value, .req_chan, .rsp_valid, .rsp_stall, .rsp_chan,
      .rsp_segment_used, .rsp_out_of_range, .psel, .penable, .pwrite, .paddr,
      .pwdata, .pready, .pending, .failures
   );

   always @(negedge clock) begin
      rsp_stall <= gaps_on && ($urandom_range(99) < 34);
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (psel && penable)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles == STALL_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   function automatic logic [31:0] pick_value();
      case ($urandom_range(9))
         0: return 32'h8000_0000;
         1: return 32'h7FFF_FFFF;
         2: return 32'h0000_0000;
         default: return $urandom;
      endcase
   endfunction

   task automatic send_item(logic [0:0] kind, logic [9:0] row, logic [31:0] t,
                            bit random_values = 1'b1);
      while (gaps_on && $urandom_range(99) < 34) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_type <= kind;
      req_row_index <= row;
      req_time_value <= t;
      if (random_values) begin
         for (int c = 0; c < NUM_CHAN; c++) req_chan[c] <= pick_value();
      end
      if (kind == REQ_LOAD) time_shadow[row] = t;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   task automatic send_row(logic [9:0] row, logic [31:0] t, logic [31:0] v0,
                           logic [31:0] v1);
      for (int c = 0; c < NUM_CHAN; c++) req_chan[c] <= c[0] ? v1 : v0;
      send_item(REQ_LOAD, row, t, 1'b0);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (20) @(negedge clock);
   endtask

   task automatic write_entry_count(logic [10:0] value);
      drain();
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= ENTRY_COUNT_ADDR;
      pwdata <= {21'd0, value};
      @(negedge clock);
      penable <= 1'b1;
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      active_rows = (value < 2) ? 2 : (value > TABLE_DEPTH) ? TABLE_DEPTH : value;
   endtask

   task automatic fill_rows(int upto);
      logic [31:0] t;
      int unsigned step_max;
      step_max = 32'hFFFF_FFFF / 1100;
      for (int r = rows_filled; r < upto; r++) begin
         if (r == 0) t = $urandom_range(1000);
         else if ($urandom_range(19) == 0) t = time_shadow[r - 1];
         else t = time_shadow[r - 1] + $urandom_range(step_max, 1);
         send_item(REQ_LOAD, 10'(r), t);
      end
      if (upto > rows_filled) rows_filled = upto;
   endtask

   task automatic random_item();
      int unsigned r;
      logic [31:0] lo;
      logic [31:0] hi;
      logic [31:0] t;
      if ($urandom_range(99) < 40) begin
         r = $urandom_range(rows_filled - 1);
         if ($urandom_range(99) < 70) begin
            lo = (r > 0) ? time_shadow[r - 1] : 32'h0;
            hi = (r < rows_filled - 1) ? time_shadow[r + 1] : 32'hFFFF_FFFF;
            t = (hi > lo) ? lo + 32'(64'($urandom) % (64'(hi - lo) + 1)) : lo;
         end else begin
            t = $urandom;
         end
         send_item(REQ_LOAD, 10'(r), t);
      end else begin
         lo = time_shadow[0];
         hi = time_shadow[active_rows - 1];
         case ($urandom_range(9))
            0, 1: t = $urandom;
            2: t = time_shadow[$urandom_range(active_rows - 1)];
            default: t = (hi > lo) ? lo + 32'(64'($urandom) % (64'(hi - lo) + 1)) : lo;
         endcase
         send_item(REQ_QUERY, 10'($urandom), t);
      end
   endtask

   initial begin
      int counts [10] = '{4, 17, 0, 64, 2047, 1, 1024, 300, 2, 1000};
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Two-row table spanning the whole time range with extreme values.
      send_row(10'd0, 32'h0000_0000, 32'h8000_0000, 32'h7FFF_FFFF);
      send_row(10'd1, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000);
      send_item(REQ_QUERY, 10'd0, 32'h0000_0000);
      send_item(REQ_QUERY, 10'd0, 32'hFFFF_FFFF);
      send_item(REQ_QUERY, 10'd0, 32'h8000_0000);
      // Equal row times, queries below the table and at the row time.
      send_row(10'd0, 32'd1000, 32'h0001_0000, 32'hFFFF_0000);
      send_row(10'd1, 32'd1000, 32'h7FFF_FFFF, 32'h8000_0000);
      send_item(REQ_QUERY, 10'd0, 32'd500);
      send_item(REQ_QUERY, 10'd0, 32'd1000);
      // Extrapolation far in both directions and the first and last rows' times.
      send_row(10'd1, 32'd3000, 32'h8000_0000, 32'h7FFF_FFFF);
      send_item(REQ_QUERY, 10'd0, 32'd0);
      send_item(REQ_QUERY, 10'd0, 32'hFFFF_FFFF);
      send_item(REQ_QUERY, 10'd0, 32'd3000);
      send_item(REQ_QUERY, 10'd0, 32'd1000);
      // Row times in falling order.
      send_row(10'd0, 32'd5000, 32'h0000_1234, 32'h0000_0000);
      send_row(10'd1, 32'd2000, 32'hFFFF_1234, 32'h7FFF_FFFF);
      send_item(REQ_QUERY, 10'd0, 32'd3000);
      send_item(REQ_QUERY, 10'd0, 32'd6000);
      send_row(10'd1023, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000);
      send_row(10'd0, 32'd0, 32'h0, 32'h0);
      send_row(10'd1, 32'd100, 32'h0010_0000, 32'hFFF0_0000);
      rows_filled = 2;
      time_shadow[0] = 32'd0;
      time_shadow[1] = 32'd100;

      foreach (counts[i]) begin
         write_entry_count(11'(counts[i]));
         gaps_on = (i != 3);
         fill_rows(active_rows);
         repeat (23) random_item();
         gaps_on = 1'b1;
      end

      drain();
      if (failures == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
